@@ rtl/assert_macros.svh @@
// Assertion helpers; the enclosing scope provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define NPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/nps_pkg.sv @@
`default_nettype none

package nps_pkg;

  localparam int IDX_W   = 10;
  localparam int COORD_W = 16;
  localparam int CNT_W   = 11;
  localparam int DIST_W  = 34;
  localparam int SQ_W    = 2 * COORD_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_QUERY,
    CMD_SKIP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic [IDX_W-1:0]           entry_index;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/nps_front.sv @@
`default_nettype none

module nps_front #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_opcode,
  input  wire logic [nps_pkg::IDX_W-1:0]            in_entry_index,
  input  wire logic signed [nps_pkg::COORD_W-1:0]   in_coord_x,
  input  wire logic signed [nps_pkg::COORD_W-1:0]   in_coord_y,
  output logic                                      cmd_valid,
  output nps_pkg::cmd_t                             cmd,
  input  wire logic                                 cmd_ready
);
  import nps_pkg::*;

  localparam int RW = (IDX_W > $clog2(MAX_POINTS + 1)) ? IDX_W : $clog2(MAX_POINTS + 1);

  cmd_t        queue_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  cmd_t        cls;
  logic        in_range;
  logic        push;
  logic        pop;

  assign in_range = RW'(in_entry_index) < RW'(MAX_POINTS);

  // Classify the incoming transaction; out-of-range writes become no-ops.
  always_comb begin
    cls.entry_index = in_entry_index;
    cls.coord_x     = in_coord_x;
    cls.coord_y     = in_coord_y;
    case (in_opcode)
      OP_WRITE: cls.kind = in_range ? CMD_WRITE : CMD_SKIP;
      OP_QUERY: cls.kind = CMD_QUERY;
      default:  cls.kind = CMD_SKIP;
    endcase
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = queue_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        queue_r[wr_ptr_r] <= cls;
        wr_ptr_r          <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/nps_back.sv @@
`default_nettype none

module nps_back #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cmd_valid,
  input  wire nps_pkg::cmd_t                 cmd,
  output logic                               cmd_ready,
  input  wire logic [nps_pkg::CNT_W-1:0]     point_count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_found,
  output logic [nps_pkg::IDX_W-1:0]          out_nearest_index,
  output logic [nps_pkg::DIST_W-1:0]         out_min_distance
);
  import nps_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = (CNT_W > $clog2(MAX_POINTS + 1)) ? CNT_W : $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESP
  } state_t;

  state_t                     state_r;
  logic [2*COORD_W-1:0]       mem [MAX_POINTS];
  logic [2*COORD_W-1:0]       rd_data_r;
  logic                       mem_we;

  logic signed [COORD_W-1:0]  qx_r;
  logic signed [COORD_W-1:0]  qy_r;
  logic [AW-1:0]              scan_idx_r;
  logic [AW-1:0]              last_idx_r;

  logic                       v1_r, v2_r, v3_r;
  logic                       last1_r, last2_r, last3_r;
  logic [AW-1:0]              idx1_r, idx2_r, idx3_r;
  logic [COORD_W-1:0]         magx_r, magy_r;
  logic [SQ_W-1:0]            sqx_r, sqy_r;

  logic                       have_r;
  logic [AW-1:0]              best_idx_r;
  logic [DIST_W-1:0]          best_d_r;
  logic                       out_valid_r;

  logic [CW-1:0]              cnt_ext;
  logic [CW-1:0]              cnt_clamp;
  logic signed [COORD_W:0]    dx;
  logic signed [COORD_W:0]    dy;
  logic [DIST_W-1:0]          dist_sum;
  logic                       better;
  logic                       load_out;

  assign cnt_ext   = CW'(point_count);
  assign cnt_clamp = (cnt_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : cnt_ext;

  assign cmd_ready = (state_r == ST_IDLE);
  assign mem_we    = cmd_valid && cmd_ready && (cmd.kind == CMD_WRITE);

  // Point store: x in the low half, y in the high half.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(cmd.entry_index)] <= {cmd.coord_y, cmd.coord_x};
    end
    rd_data_r <= mem[scan_idx_r];
  end

  assign dx = $signed({qx_r[COORD_W-1], qx_r})
            - $signed({rd_data_r[COORD_W-1], rd_data_r[COORD_W-1:0]});
  assign dy = $signed({qy_r[COORD_W-1], qy_r})
            - $signed({rd_data_r[2*COORD_W-1], rd_data_r[2*COORD_W-1:COORD_W]});

  assign dist_sum = DIST_W'(sqx_r) + DIST_W'(sqy_r);
  assign better   = !have_r || (dist_sum < best_d_r);
  assign load_out = (state_r == ST_RESP) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Scan pipeline: read, difference magnitude, square, accumulate.
      v1_r    <= (state_r == ST_SCAN);
      last1_r <= (scan_idx_r == last_idx_r);
      idx1_r  <= scan_idx_r;

      v2_r    <= v1_r;
      last2_r <= last1_r;
      idx2_r  <= idx1_r;
      magx_r  <= COORD_W'(dx[COORD_W] ? -dx : dx);
      magy_r  <= COORD_W'(dy[COORD_W] ? -dy : dy);

      v3_r    <= v2_r;
      last3_r <= last2_r;
      idx3_r  <= idx2_r;
      sqx_r   <= SQ_W'(magx_r) * SQ_W'(magx_r);
      sqy_r   <= SQ_W'(magy_r) * SQ_W'(magy_r);

      if (v3_r && better) begin
        have_r     <= 1'b1;
        best_d_r   <= dist_sum;
        best_idx_r <= idx3_r;
      end

      if (load_out) begin
        out_valid_r       <= 1'b1;
        out_found         <= have_r;
        out_nearest_index <= IDX_W'(best_idx_r);
        out_min_distance  <= best_d_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (cmd_valid && cmd.kind == CMD_QUERY) begin
            qx_r       <= cmd.coord_x;
            qy_r       <= cmd.coord_y;
            scan_idx_r <= '0;
            last_idx_r <= AW'(cnt_clamp - CW'(1));
            have_r     <= 1'b0;
            best_d_r   <= '0;
            best_idx_r <= '0;
            state_r    <= (cnt_clamp == '0) ? ST_RESP : ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_idx_r <= scan_idx_r + AW'(1);
          if (scan_idx_r == last_idx_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (v3_r && last3_r) begin
            state_r <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/nearest_point_search_unit.sv @@
// Brute-force 2D nearest-point search over a store of up to MAX_POINTS
// signed Q1.14 points. A write transaction (opcode 0) stores one point and
// returns nothing; a query transaction (opcode 1) scans entries 0 to
// point_count-1 and returns the first index at the smallest squared
// distance, with that distance in raw 2^-28 units, or found = 0 when the
// count is zero. A query scans through the single read port of the point
// store, which delivers one entry per cycle to a four-stage distance
// pipeline. A two-entry command queue keeps accepting input while a
// search runs, and a result register holds the last answer until it is
// taken. Read only entries that have been written; the user must write
// point_count only while the block is idle, which the block itself does
// not enforce, and the count used is capped at MAX_POINTS.
`default_nettype none

`include "assert_macros.svh"

module nearest_point_search_unit #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_write_en,
  input  wire logic [nps_pkg::CNT_W-1:0]            cfg_write_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_opcode,
  input  wire logic [nps_pkg::IDX_W-1:0]            in_entry_index,
  input  wire logic signed [nps_pkg::COORD_W-1:0]   in_coord_x,
  input  wire logic signed [nps_pkg::COORD_W-1:0]   in_coord_y,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_found,
  output logic [nps_pkg::IDX_W-1:0]                 out_nearest_index,
  output logic [nps_pkg::DIST_W-1:0]                out_min_distance
);
  import nps_pkg::*;

  logic [CNT_W-1:0]  point_count_r;
  logic              cmd_valid;
  logic              cmd_ready;
  cmd_t              cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
    end else if (cfg_write_en) begin
      point_count_r <= cfg_write_data;
    end
  end

  nps_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_entry_index (in_entry_index),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_ready      (cmd_ready)
  );

  nps_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_ready         (cmd_ready),
    .point_count       (point_count_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_nearest_index (out_nearest_index),
    .out_min_distance  (out_min_distance)
  );

  `NPS_ASSERT_IMP(a_empty_result_zero, out_valid && !out_found, (out_min_distance == '0) && (out_nearest_index == '0), "empty search result carries nonzero fields")
  `NPS_ASSERT_NXT(a_query_blocks_engine, cmd_valid && cmd_ready && (cmd.kind == CMD_QUERY), !cmd_ready, "engine took a command during a search")
  `NPS_ASSERT_IMP(a_full_queue_pending, !in_ready, cmd_valid, "input stalled with an empty command queue")

endmodule

`default_nettype wire

@@ tb/nearest_point_search_unit_tb.sv @@
`timescale 1ns / 1ps

module nearest_point_search_unit_tb;
  import nps_pkg::*;

  localparam int MAX_ENTRIES   = 1024;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 8000;

  typedef struct {
    logic                      opcode;
    logic [IDX_W-1:0]          entry;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_cmd_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
  } search_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_write_en = 1'b0;
  logic [CNT_W-1:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_opcode = OP_WRITE;
  logic [IDX_W-1:0] in_entry_index = '0;
  logic signed [COORD_W-1:0] in_coord_x = '0;
  logic signed [COORD_W-1:0] in_coord_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_found;
  logic [IDX_W-1:0] out_nearest_index;
  logic [DIST_W-1:0] out_min_distance;

  // Stimulus side
  point_cmd_t pending_cmds[$];
  logic signed [COORD_W-1:0] gen_x [MAX_ENTRIES];
  logic signed [COORD_W-1:0] gen_y [MAX_ENTRIES];
  bit gen_written [MAX_ENTRIES];
  int issued_cnt = 0;
  int send_idle_pct = 21;
  int recv_idle_pct = 75;
  int stall_requests = 0;
  int stalls_served = 0;
  int hold_left = 0;
  int phases_run = 0;

  // Prediction side
  logic signed [COORD_W-1:0] store_x [MAX_ENTRIES];
  logic signed [COORD_W-1:0] store_y [MAX_ENTRIES];
  int search_count = 0;
  search_result_t expected_nearest[$];
  int accepted_cnt = 0;
  int writes_seen = 0;
  int queries_seen = 0;
  int results_checked = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  nearest_point_search_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_entry_index    (in_entry_index),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_nearest_index (out_nearest_index),
    .out_min_distance  (out_min_distance)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Exhaustive scan, first strict minimum wins.
  function automatic search_result_t predict_nearest(input logic signed [COORD_W-1:0] qx,
                                                     input logic signed [COORD_W-1:0] qy);
    search_result_t res;
    int n;
    longint dx;
    longint dy;
    longint d;
    res = '0;
    n = (search_count > MAX_ENTRIES) ? MAX_ENTRIES : search_count;
    for (int i = 0; i < n; i++) begin
      dx = longint'(qx) - longint'(store_x[i]);
      dy = longint'(qy) - longint'(store_y[i]);
      d = dx * dx + dy * dy;
      if (!res.found || d < longint'(res.distance)) begin
        res.found = 1'b1;
        res.distance = d[DIST_W-1:0];
        res.index = i[IDX_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(19))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin : driver
    point_cmd_t cmd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_opcode <= cmd.opcode;
        in_entry_index <= cmd.entry;
        in_coord_x <= cmd.x;
        in_coord_y <= cmd.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_requests != stalls_served) begin
      // long hold-off so the command queue backs up into the input
      stalls_served++;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    search_result_t exp_res;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (in_opcode == OP_WRITE) begin
          store_x[in_entry_index] = in_coord_x;
          store_y[in_entry_index] = in_coord_y;
          writes_seen++;
        end else begin
          expected_nearest = {expected_nearest, predict_nearest(in_coord_x, in_coord_y)};
          queries_seen++;
        end
        accepted_cnt++;
      end
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_nearest.size() == 0) begin
          $error("result transaction with no query pending");
          fail_count++;
        end else begin
          exp_res = expected_nearest.pop_front();
          if (out_found !== exp_res.found) begin
            $error("found: expected %0d, got %0d", exp_res.found, out_found);
            fail_count++;
          end
          if (out_nearest_index !== exp_res.index) begin
            $error("nearest_index: expected %0d, got %0d", exp_res.index, out_nearest_index);
            fail_count++;
          end
          if (out_min_distance !== exp_res.distance) begin
            $error("min_distance: expected %0d, got %0d", exp_res.distance,
                   out_min_distance);
            fail_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic push_write(input int idx, input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
    point_cmd_t cmd;
    cmd.opcode = OP_WRITE;
    cmd.entry = idx[IDX_W-1:0];
    cmd.x = x;
    cmd.y = y;
    gen_x[idx] = x;
    gen_y[idx] = y;
    gen_written[idx] = 1'b1;
    pending_cmds = {pending_cmds, cmd};
    issued_cnt++;
  endtask

  task automatic push_query(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
    point_cmd_t cmd;
    cmd.opcode = OP_QUERY;
    cmd.entry = IDX_W'($urandom);
    cmd.x = x;
    cmd.y = y;
    pending_cmds = {pending_cmds, cmd};
    issued_cnt++;
  endtask

  task automatic wait_drained();
    while (accepted_cnt != issued_cnt || expected_nearest.size() != 0) @(posedge clk);
  endtask

  // Writes leave no result behind, so give the engine time to retire them.
  task automatic program_count(input int value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value[CNT_W-1:0];
    @(posedge clk);
    cfg_write_en <= 1'b0;
    search_count = value;
    phases_run++;
  endtask

  task automatic random_phase(input int n_items, input bit pause_mid, input bit hold_out);
    int prefix;
    int cnt;
    int pick;
    int k;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    prefix = 0;
    while (prefix < MAX_ENTRIES && gen_written[prefix]) prefix++;
    pick = $urandom_range(99);
    if (pick < 8) cnt = 0;
    else if (pick < 18) cnt = 1;
    else if (pick < 80) cnt = $urandom_range(2, 16);
    else cnt = $urandom_range(17, prefix);
    program_count(cnt);
    if (hold_out) stall_requests++;
    for (int i = 0; i < n_items; i++) begin
      if (pause_mid && i == n_items / 2) wait_drained();
      if ($urandom_range(99) < 45) begin
        if (cnt > 0 && $urandom_range(99) < 40) begin
          // land near a stored point to get close calls and exact hits
          k = $urandom_range(cnt - 1);
          x = gen_x[k] + COORD_W'($urandom_range(8)) - COORD_W'(4);
          y = gen_y[k] + COORD_W'($urandom_range(8)) - COORD_W'(4);
        end else begin
          x = rand_coord();
          y = rand_coord();
        end
        push_query(x, y);
      end else begin
        if (cnt > 0 && $urandom_range(99) < 60) k = $urandom_range(cnt - 1);
        else k = $urandom_range(MAX_ENTRIES - 1);
        if ($urandom_range(99) < 25) begin
          // duplicate an existing point to force ties
          pick = $urandom_range(prefix - 1);
          x = gen_x[pick];
          y = gen_y[pick];
        end else begin
          x = rand_coord();
          y = rand_coord();
        end
        push_write(k, x, y);
      end
    end
  endtask

  initial begin
    int span;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty search, coordinate extremes, ties, top store index.
    program_count(0);
    push_query(16'sh0000, 16'sh0000);
    push_query(16'sh8000, 16'sh7fff);
    push_write(0, 16'sh8000, 16'sh8000);
    push_write(1, 16'sh7fff, 16'sh7fff);
    push_write(2, 16'sd100, 16'sd200);
    push_write(3, 16'sd200, 16'sd100);
    push_write(4, 16'sd100, 16'sd200);
    push_write(MAX_ENTRIES - 1, 16'shffff, 16'shffff);
    program_count(1);
    push_query(16'sh7fff, 16'sh7fff);
    push_query(16'sh8000, 16'sh8000);
    program_count(5);
    push_query(16'sh0000, 16'sh0000);
    push_query(16'sh7fff, 16'sh7fff);
    push_query(16'sh8000, 16'sh7fff);
    push_query(16'sd150, 16'sd150);

    // Seed the low part of the store so random phases can search it.
    for (int i = 0; i < 64; i++) begin
      if (i > 0 && $urandom_range(99) < 20) begin
        push_write(i, gen_x[i - 1], gen_y[i - 1]);
      end else begin
        push_write(i, rand_coord(), rand_coord());
      end
    end

    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 21 : (m == 1) ? 75 : 0;
      recv_idle_pct = (m == 0) ? 75 : (m == 1) ? 21 : 0;
      for (int p = 0; p < 4; p++) random_phase(42, m == 1 && p == 2, p == 0);
    end

    // Search the longest written stretch at the bottom of the store.
    span = 0;
    while (span < MAX_ENTRIES && gen_written[span]) span++;
    program_count(span);
    push_query(16'sh4321, 16'shbcde);
    push_query(16'sh8000, 16'sh8000);
    push_query(rand_coord(), rand_coord());

    wait_drained();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    $display("summary: %0d writes, %0d queries, %0d search results checked",
             writes_seen, queries_seen, results_checked);
    $display("summary: %0d point_count settings, the widest searching %0d entries, %s",
             phases_run, span, "three idle profiles");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ nearest_point_search_unit.f @@
+incdir+rtl
rtl/nps_pkg.sv
rtl/nps_front.sv
rtl/nps_back.sv
rtl/nearest_point_search_unit.sv
tb/nearest_point_search_unit_tb.sv
